[rtl/sorted_priority_queue_unit_defines.svh]
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int OCC_W        = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_LIST = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_LIST  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_REQ,
    SEL_HEAD,
    SEL_ZERO
  } out_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     idx_clr;
    logic     out_load;
    status_t  status;
    out_sel_t sel;
    logic     last;
  } dp_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_emit;
    logic list_last;
    logic list_end;
  } dp_stat_t;

endpackage

[rtl/spq_ifs.sv]
// Request and result channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::CMD_W-1:0]           command;
  logic signed [spq_pkg::DATA_W-1:0]   value;
  logic signed [spq_pkg::DATA_W-1:0]   priority_req;

  modport source (output valid, command, value, priority_req, input ready);
  modport sink   (input valid, command, value, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic signed [spq_pkg::DATA_W-1:0]   value_res;
  logic signed [spq_pkg::DATA_W-1:0]   priority_res;
  logic [spq_pkg::OCC_W-1:0]           occupancy;
  logic                                last;

  modport source (output valid, status, value_res, priority_res, occupancy, last,
                  input ready);
  modport sink   (input valid, status, value_res, priority_res, occupancy, last,
                  output ready);
endinterface

[rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue.
// The queue holds up to CAPACITY entries in ascending priority order (smaller
// signed priority first, equal priorities in arrival order), one register
// cell per entry with its own comparator. On enqueue every cell compares
// against the new priority in parallel, and on enqueue and dequeue the cells
// shift as one, so a new request is taken every cycle while results are
// being taken. A read-out rotates the cell array by one place each cycle,
// sending out the head, until every held entry has gone round once; a
// rotation that gives a result waits until the output register is free or
// being emptied, and no new request is taken meanwhile. At most the first
// sixteen entries give a result, any beyond that only rotate back into
// place. A held result waits in the output register; a request is taken only
// when it is free or being emptied. Command code 3 is taken and ignored.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::dp_ctrl_t ctrl;
  spq_pkg::dp_stat_t stat;
  logic [CNT_W-1:0]  count;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (spq_pkg::cmd_t'(in_chan.command)),
    .in_ready   (in_chan.ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_value      (in_chan.value),
    .in_priority   (in_chan.priority_req),
    .stat          (stat),
    .count         (count),
    .out_status    (out_chan.status),
    .out_value     (out_chan.value_res),
    .out_priority  (out_chan.priority_res),
    .out_occupancy (out_chan.occupancy),
    .out_last      (out_chan.last)
  );

  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, int'(count) <= CAPACITY, "count above capacity")
  `SPQ_ASSERT_NOW(a_no_req_on_stall, clk, rst_n, out_chan.valid && !out_chan.ready, !in_chan.ready, "request taken while result stalled")
  `SPQ_ASSERT_NEXT(a_enq_result, clk, rst_n, in_chan.valid && in_chan.ready && (in_chan.command == spq_pkg::CMD_ENQ), out_chan.valid && out_chan.last && ((out_chan.status == spq_pkg::ST_ENQ) || (out_chan.status == spq_pkg::ST_FULL)), "enqueue gave no result")
  `SPQ_ASSERT_NEXT(a_deq_empty, clk, rst_n, in_chan.valid && in_chan.ready && (in_chan.command == spq_pkg::CMD_DEQ) && stat.empty, out_chan.valid && (out_chan.status == spq_pkg::ST_EMPTY) && (out_chan.value_res == '0), "dequeue on empty queue misreported")

endmodule

[rtl/spq_ctrl.sv]
// Controller state machine of the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  spq_pkg::cmd_t     in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_ctrl_t ctrl
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  // The result register can take a new result when empty or being emptied.
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctrl.op       = spq_pkg::OP_HOLD;
    ctrl.idx_clr  = 1'b0;
    ctrl.out_load = 1'b0;
    ctrl.status   = spq_pkg::ST_ENQ;
    ctrl.sel      = spq_pkg::SEL_REQ;
    ctrl.last     = 1'b1;
    case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          case (in_command)
            spq_pkg::CMD_ENQ: begin
              ctrl.out_load = 1'b1;
              ctrl.sel      = spq_pkg::SEL_REQ;
              if (stat.full) begin
                ctrl.status = spq_pkg::ST_FULL;
              end else begin
                ctrl.op     = spq_pkg::OP_INSERT;
                ctrl.status = spq_pkg::ST_ENQ;
              end
            end
            spq_pkg::CMD_DEQ: begin
              ctrl.out_load = 1'b1;
              if (stat.empty) begin
                ctrl.status = spq_pkg::ST_EMPTY;
                ctrl.sel    = spq_pkg::SEL_ZERO;
              end else begin
                ctrl.op     = spq_pkg::OP_REMOVE;
                ctrl.status = spq_pkg::ST_DEQ;
                ctrl.sel    = spq_pkg::SEL_HEAD;
              end
            end
            spq_pkg::CMD_LIST: begin
              if (stat.empty) begin
                ctrl.out_load = 1'b1;
                ctrl.status   = spq_pkg::ST_EMPTY;
                ctrl.sel      = spq_pkg::SEL_ZERO;
              end else begin
                ctrl.idx_clr = 1'b1;
                state_nxt    = spq_pkg::S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::S_LIST: begin
        // The list is rotated once per entry so that it is back in order at
        // the end; entries past the result limit rotate without a result.
        ctrl.status = spq_pkg::ST_LIST;
        ctrl.sel    = spq_pkg::SEL_HEAD;
        ctrl.last   = stat.list_last;
        if (!stat.list_emit || slot_free) begin
          ctrl.op       = spq_pkg::OP_ROTATE;
          ctrl.out_load = stat.list_emit;
          if (stat.list_end) begin
            state_nxt = spq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = ctrl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

endmodule

[rtl/spq_datapath.sv]
// Datapath of the sorted priority queue: sorted entry cells and result register.
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::dp_ctrl_t                 ctrl,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  input  logic signed [spq_pkg::DATA_W-1:0] in_priority,
  output spq_pkg::dp_stat_t                 stat,
  output logic [CNT_W-1:0]                  count,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic signed [spq_pkg::DATA_W-1:0] out_value,
  output logic signed [spq_pkg::DATA_W-1:0] out_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_last
);

  logic signed [spq_pkg::DATA_W-1:0] cell_v_r [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_p_r [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_v_nxt [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] cell_p_nxt [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] up_v [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] up_p [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] dn_v [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] dn_p [CAPACITY];
  logic [CAPACITY-1:0]               ins;
  logic [CAPACITY-1:0]               prev_ins;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  int               list_len;

  logic [spq_pkg::STATUS_W-1:0]      status_r;
  logic signed [spq_pkg::DATA_W-1:0] value_r;
  logic signed [spq_pkg::DATA_W-1:0] priority_r;
  logic [spq_pkg::OCC_W-1:0]         occ_r;
  logic                              last_r;
  logic signed [spq_pkg::DATA_W-1:0] sel_v, sel_p;

  // Neighbour taps of each cell: the one above for shifting towards the head,
  // the one below for opening a gap on insertion.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
    if (g == CAPACITY - 1) begin : g_top
      assign up_v[g] = cell_v_r[0];
      assign up_p[g] = cell_p_r[0];
    end else begin : g_mid
      assign up_v[g] = cell_v_r[g+1];
      assign up_p[g] = cell_p_r[g+1];
    end
    if (g == 0) begin : g_head
      assign dn_v[g]     = in_value;
      assign dn_p[g]     = in_priority;
      assign prev_ins[g] = 1'b0;
    end else begin : g_rest
      assign dn_v[g]     = cell_v_r[g-1];
      assign dn_p[g]     = cell_p_r[g-1];
      assign prev_ins[g] = ins[g-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      // The new entry goes before every held entry of strictly greater priority.
      ins[i] = (i >= int'(count_r)) || (cell_p_r[i] > in_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_v_nxt[i] = cell_v_r[i];
      cell_p_nxt[i] = cell_p_r[i];
      case (ctrl.op)
        spq_pkg::OP_INSERT: begin
          if (ins[i]) begin
            cell_v_nxt[i] = prev_ins[i] ? dn_v[i] : in_value;
            cell_p_nxt[i] = prev_ins[i] ? dn_p[i] : in_priority;
          end
        end
        spq_pkg::OP_REMOVE: begin
          cell_v_nxt[i] = up_v[i];
          cell_p_nxt[i] = up_p[i];
        end
        spq_pkg::OP_ROTATE: begin
          if (i == int'(count_r) - 1) begin
            cell_v_nxt[i] = cell_v_r[0];
            cell_p_nxt[i] = cell_p_r[0];
          end else begin
            cell_v_nxt[i] = up_v[i];
            cell_p_nxt[i] = up_p[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_v_r[i] <= cell_v_nxt[i];
      cell_p_r[i] <= cell_p_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (ctrl.op)
      spq_pkg::OP_INSERT: count_nxt = count_r + CNT_W'(1);
      spq_pkg::OP_REMOVE: count_nxt = count_r - CNT_W'(1);
      default:            count_nxt = count_r;
    endcase
    idx_nxt = idx_r;
    if (ctrl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctrl.op == spq_pkg::OP_ROTATE) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign list_len = (int'(count_r) < spq_pkg::MAX_RESULTS) ? int'(count_r)
                                                           : spq_pkg::MAX_RESULTS;

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (int'(count_r) >= CAPACITY);
  assign stat.list_emit = (int'(idx_r) < spq_pkg::MAX_RESULTS);
  assign stat.list_last = (int'(idx_r) + 1 == list_len);
  assign stat.list_end  = (int'(idx_r) + 1 == int'(count_r));
  assign count          = count_r;

  always_comb begin
    case (ctrl.sel)
      spq_pkg::SEL_REQ: begin
        sel_v = in_value;
        sel_p = in_priority;
      end
      spq_pkg::SEL_HEAD: begin
        sel_v = cell_v_r[0];
        sel_p = cell_p_r[0];
      end
      default: begin
        sel_v = '0;
        sel_p = '0;
      end
    endcase
  end

  // Result register; occupancy is the count after this request, to five bits.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      status_r   <= ctrl.status;
      value_r    <= sel_v;
      priority_r <= sel_p;
      occ_r      <= spq_pkg::OCC_W'(count_nxt);
      last_r     <= ctrl.last;
    end
  end

  assign out_status    = status_r;
  assign out_value     = value_r;
  assign out_priority  = priority_r;
  assign out_occupancy = occ_r;
  assign out_last      = last_r;

endmodule
